// ----- rtl/tbmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmm_pkg
// Shared types and constants of the time bucket min/max/mean downsampler.
// ----------------------------------------------------------------------------
package tbmm_pkg;

  localparam int unsigned Probes = 4;
  localparam int unsigned NumPr  = (Probes < 4) ? Probes : 4;
  localparam int unsigned PrW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [15:0] Int16Max = 16'sh7fff;
  localparam logic signed [15:0] Int16Min = 16'sh8000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegAggEn     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStride    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBucketSec = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStart     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStop      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDetached  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInvalid   = 3'd6;

  typedef struct packed {
    logic        action;
    logic [31:0] sample_time;
    logic signed [15:0] temp_probe0;
    logic signed [15:0] temp_probe1;
    logic signed [15:0] temp_probe2;
    logic signed [15:0] temp_probe3;
    logic [7:0]  sample_status;
    logic signed [7:0] signal_strength;
    logic        record_good;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] result_time;
    logic [1:0]  probe_number;
    logic signed [15:0] raw_value;
    logic signed [15:0] bucket_min;
    logic signed [15:0] bucket_max;
    logic signed [15:0] bucket_mean;
    logic [15:0] bucket_records;
    logic [7:0]  status_out;
    logic signed [7:0] strength_out;
    logic        last_of_run;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle, StCheck, StModStart, StModRun, StBucket,
    StEmitRaw, StDivStart, StDivRun, StEmitSum, StAccum, StFlushClr
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;      // capture input word
    logic mod_start;    // start t mod len
    logic div_start;    // start divide for probe sel
    logic emit_raw;     // present raw word for probe sel
    logic emit_sum;     // present summary word for probe sel
    logic open_bucket;  // clear accumulators and open at t0
    logic accum;        // fold record into bucket
    logic clear_all;    // end action: clear bucket, counter, past_stop
    logic set_past;     // set past_stop
    logic bump_kept;    // advance stride counter
    logic [PrW-1:0] sel;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_end;
    logic drop;
    logic over_stop;
    logic agg;
    logic fire;
    logic bucket_open;
    logic same_bucket;
    logic mod_done;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/tbmm_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmm_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface tbmm_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tbmm_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmm_divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbmm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  logic [31:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  // one shift-subtract step
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d  = {rem_q[30:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ----- rtl/tbmm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmm_datapath
// Config registers, bucket accumulators, divider and output register.
// ----------------------------------------------------------------------------
module tbmm_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tbmm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbmm_pkg::CfgDataW-1:0] cfg_data_i,
  input  tbmm_pkg::in_word_t in_word_i,
  input  tbmm_pkg::ctrl_t ctrl_i,
  output tbmm_pkg::stat_t stat_o,
  tbmm_stream_if.source out_o
);
  localparam int unsigned N = tbmm_pkg::NumPr;

  // config
  logic        agg_q;
  logic [15:0] stride_q;
  logic [31:0] bsec_q, start_q, stop_q;
  logic signed [15:0] det_q, inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_q    <= 1'b0;
      stride_q <= 16'd1;
      bsec_q   <= 32'd60;
      start_q  <= '0;
      stop_q   <= '1;
      det_q    <= tbmm_pkg::Int16Min;
      inv_q    <= 16'sh8001;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbmm_pkg::RegAggEn:     agg_q    <= cfg_data_i[0];
        tbmm_pkg::RegStride:    stride_q <= cfg_data_i[15:0];
        tbmm_pkg::RegBucketSec: bsec_q   <= cfg_data_i;
        tbmm_pkg::RegStart:     start_q  <= cfg_data_i;
        tbmm_pkg::RegStop:      stop_q   <= cfg_data_i;
        tbmm_pkg::RegDetached:  det_q    <= cfg_data_i[15:0];
        tbmm_pkg::RegInvalid:   inv_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // captured input word
  tbmm_pkg::in_word_t w_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) w_q <= in_word_i;
  end

  logic signed [15:0] v [N];
  always_comb begin
    logic signed [15:0] all4 [4];
    all4[0] = w_q.temp_probe0;
    all4[1] = w_q.temp_probe1;
    all4[2] = w_q.temp_probe2;
    all4[3] = w_q.temp_probe3;
    for (int i = 0; i < N; i++) v[i] = all4[i];
  end

  // state
  logic        open_q, past_q;
  logic [31:0] bstart_q;
  logic [15:0] brec_q, kept_q;
  logic signed [15:0] mn_q [N];
  logic signed [15:0] mx_q [N];
  logic signed [31:0] sum_q [N];
  logic [15:0] cnt_q [N];

  // shared divider: modulo for bucket start, then per-probe mean
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_quot, div_rem;
  logic        neg;
  logic [31:0] sum_abs;
  assign neg     = sum_q[ctrl_i.sel][31];
  assign sum_abs = neg ? (32'd0 - sum_q[ctrl_i.sel]) : sum_q[ctrl_i.sel];
  assign div_start = ctrl_i.mod_start | ctrl_i.div_start;
  assign div_a = ctrl_i.mod_start ? w_q.sample_time : sum_abs;
  assign div_b = ctrl_i.mod_start ? ((bsec_q == '0) ? 32'd1 : bsec_q)
                                  : {16'd0, cnt_q[ctrl_i.sel]};

  tbmm_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a),
    .divisor_i(div_b), .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  // divider use: 0 bucket modulo, 1 mean
  logic mean_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mean_q <= 1'b0;
    else if (ctrl_i.mod_start) mean_q <= 1'b0;
    else if (ctrl_i.div_start) mean_q <= 1'b1;
  end

  // bucket start, taken when the modulo finishes
  logic [31:0] t0_q;
  always_ff @(posedge clk_i) begin
    if (div_done && !mean_q) t0_q <= w_q.sample_time - div_rem;
  end

  // bucket and stride state
  logic [15:0] stride_eff;
  assign stride_eff = (stride_q == '0) ? 16'd1 : stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0; past_q <= 1'b0; bstart_q <= '0; brec_q <= '0;
      kept_q <= '0;
      for (int i = 0; i < N; i++) begin
        mn_q[i] <= tbmm_pkg::Int16Max; mx_q[i] <= tbmm_pkg::Int16Min;
        sum_q[i] <= '0; cnt_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.set_past) past_q <= 1'b1;
      if (ctrl_i.bump_kept)
        kept_q <= ({16'd0, kept_q} + 32'd1 >= {16'd0, stride_eff}) ? '0
                  : kept_q + 16'd1;
      if (ctrl_i.clear_all || ctrl_i.open_bucket) begin
        open_q <= ctrl_i.open_bucket;
        bstart_q <= ctrl_i.open_bucket ? t0_q : '0;
        brec_q <= '0;
        for (int i = 0; i < N; i++) begin
          mn_q[i] <= tbmm_pkg::Int16Max; mx_q[i] <= tbmm_pkg::Int16Min;
          sum_q[i] <= '0; cnt_q[i] <= '0;
        end
        if (ctrl_i.clear_all) begin
          kept_q <= '0; past_q <= 1'b0;
        end
      end else if (ctrl_i.accum) begin
        if (brec_q != 16'hffff) brec_q <= brec_q + 16'd1;
        for (int i = 0; i < N; i++) begin
          if (v[i] != det_q && v[i] != inv_q) begin
            if (v[i] < mn_q[i]) mn_q[i] <= v[i];
            if (v[i] > mx_q[i]) mx_q[i] <= v[i];
            if (cnt_q[i] != 16'hffff) begin
              sum_q[i] <= sum_q[i] + {{16{v[i][15]}}, v[i]};
              cnt_q[i] <= cnt_q[i] + 16'd1;
            end
          end
        end
      end
    end
  end

  // status
  assign stat_o.is_end      = w_q.action;
  assign stat_o.drop        = past_q || (w_q.sample_time < start_q) || !w_q.record_good;
  assign stat_o.over_stop   = w_q.sample_time > stop_q;
  assign stat_o.agg         = agg_q;
  assign stat_o.fire        = (kept_q == '0);
  assign stat_o.bucket_open = open_q;
  assign stat_o.same_bucket = (t0_q == bstart_q);
  assign stat_o.mod_done    = div_done;
  assign stat_o.div_done    = div_done;
  assign stat_o.out_busy    = out_o.valid;

  // output register
  tbmm_pkg::out_word_t ow;
  logic [31:0] mq;
  logic has;
  assign mq  = neg ? (32'd0 - div_quot) : div_quot;
  assign has = (cnt_q[ctrl_i.sel] != '0);
  always_comb begin
    ow = '0;
    ow.probe_number = ctrl_i.sel;
    ow.last_of_run  = ({30'd0, ctrl_i.sel} == N - 1);
    if (ctrl_i.emit_raw) begin
      ow.result_kind  = 1'b0;
      ow.result_time  = w_q.sample_time;
      ow.raw_value    = v[ctrl_i.sel];
      ow.status_out   = w_q.sample_status;
      ow.strength_out = w_q.signal_strength;
    end else begin
      ow.result_kind    = 1'b1;
      ow.result_time    = bstart_q;
      ow.bucket_min     = has ? mn_q[ctrl_i.sel] : det_q;
      ow.bucket_max     = has ? mx_q[ctrl_i.sel] : det_q;
      ow.bucket_mean    = has ? mq[15:0] : det_q;
      ow.bucket_records = brec_q;
    end
  end

  logic ovalid_q;
  tbmm_pkg::out_word_t odata_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (ctrl_i.emit_raw || ctrl_i.emit_sum) ovalid_q <= 1'b1;
    else if (out_o.ready) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_raw || ctrl_i.emit_sum) odata_q <= ow;
  end
  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;
endmodule

// ----- rtl/tbmm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmm_ctrl
// Sequencer: filter, bucket test, summary emission and accumulation.
// ----------------------------------------------------------------------------
module tbmm_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  tbmm_pkg::stat_t stat_i,
  output tbmm_pkg::ctrl_t ctrl_o
);
  localparam int unsigned N = tbmm_pkg::NumPr;

  tbmm_pkg::state_e state_q, state_d;
  logic [tbmm_pkg::PrW-1:0] sel_q, sel_d;
  logic is_last;
  assign is_last = ({30'd0, sel_q} == N - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbmm_pkg::StIdle;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      tbmm_pkg::StIdle: if (in_valid_i) state_d = tbmm_pkg::StCheck;
      tbmm_pkg::StCheck: begin
        sel_d = '0;
        if (stat_i.is_end)
          state_d = stat_i.bucket_open ? tbmm_pkg::StDivStart : tbmm_pkg::StFlushClr;
        else if (stat_i.drop || stat_i.over_stop) state_d = tbmm_pkg::StIdle;
        else if (!stat_i.agg)
          state_d = stat_i.fire ? tbmm_pkg::StEmitRaw : tbmm_pkg::StIdle;
        else state_d = tbmm_pkg::StModStart;
      end
      tbmm_pkg::StModStart: state_d = tbmm_pkg::StModRun;
      tbmm_pkg::StModRun: if (stat_i.mod_done) state_d = tbmm_pkg::StBucket;
      tbmm_pkg::StBucket:
        if (stat_i.bucket_open && stat_i.same_bucket) state_d = tbmm_pkg::StAccum;
        else if (stat_i.bucket_open) state_d = tbmm_pkg::StDivStart;
        else state_d = tbmm_pkg::StFlushClr;
      tbmm_pkg::StEmitRaw:
        if (!stat_i.out_busy) begin
          sel_d = sel_q + 1'b1;
          if (is_last) state_d = tbmm_pkg::StIdle;
        end
      tbmm_pkg::StDivStart: state_d = tbmm_pkg::StDivRun;
      tbmm_pkg::StDivRun: if (stat_i.div_done) state_d = tbmm_pkg::StEmitSum;
      tbmm_pkg::StEmitSum:
        if (!stat_i.out_busy) begin
          sel_d = sel_q + 1'b1;
          state_d = is_last ? tbmm_pkg::StFlushClr : tbmm_pkg::StDivStart;
        end
      tbmm_pkg::StFlushClr:
        state_d = stat_i.is_end ? tbmm_pkg::StIdle : tbmm_pkg::StAccum;
      tbmm_pkg::StAccum: state_d = tbmm_pkg::StIdle;
      default: state_d = tbmm_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    ctrl_o.sel = sel_q;
    in_ready_o = (state_q == tbmm_pkg::StIdle);
    ctrl_o.load_in = (state_q == tbmm_pkg::StIdle) && in_valid_i;
    unique case (state_q)
      tbmm_pkg::StCheck: begin
        if (!stat_i.is_end && !stat_i.drop) begin
          if (stat_i.over_stop) ctrl_o.set_past = 1'b1;
          else if (!stat_i.agg) ctrl_o.bump_kept = 1'b1;
        end
      end
      tbmm_pkg::StModStart: ctrl_o.mod_start = 1'b1;
      tbmm_pkg::StDivStart: ctrl_o.div_start = 1'b1;
      tbmm_pkg::StEmitRaw: ctrl_o.emit_raw = !stat_i.out_busy;
      tbmm_pkg::StEmitSum: ctrl_o.emit_sum = !stat_i.out_busy;
      tbmm_pkg::StFlushClr: begin
        if (stat_i.is_end) ctrl_o.clear_all = 1'b1;
        else ctrl_o.open_bucket = 1'b1;
      end
      tbmm_pkg::StAccum: ctrl_o.accum = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- rtl/time_bucket_min_max_mean_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_bucket_min_max_mean_top
// Time-bucketed min/max/mean downsampler for four-probe temperature records.
// ----------------------------------------------------------------------------
// One record at a time: the input is ready again only once the previous record
// is done. A fired raw pass-through record sends its four words through one
// output register, a record in aggregate mode waits on the 32-step bucket
// modulo in the shared divider, and a bucket close runs the mean division in
// that divider for each probe and then reopens or clears the bucket; any
// output stall adds to this.
module time_bucket_min_max_mean_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tbmm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbmm_pkg::CfgDataW-1:0] cfg_data_i,
  tbmm_stream_if.sink   in_i,
  tbmm_stream_if.source out_o
);
  tbmm_pkg::ctrl_t ctrl;
  tbmm_pkg::stat_t stat;

  tbmm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  tbmm_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_word_i(in_i.data), .ctrl_i(ctrl), .stat_o(stat), .out_o(out_o)
  );
endmodule
